[rtl/sur_pkg.sv]
// ----------------------------------------------------------------------------
// sur_pkg
// Shared types and constants for the spectrum uniform resampler: register
// reset values, field widths, grid point classification codes and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sur_pkg;

  localparam int GRID_POINTS_DEF = 64;

  localparam int WAVE_W  = 16;
  localparam int VAL_W   = 32;
  localparam int INDEX_W = 6;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_STEP  = 1'd1;

  localparam logic [CFG_W-1:0] GRID_START_RST = 16'd6080;
  localparam logic [CFG_W-1:0] GRID_STEP_RST  = 16'd80;

  // restoring divide: quotient magnitude is below 2**33
  localparam int DIV_STEPS = 33;
  localparam int DIV_CNT_W = 6;

  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] KIND_ZERO   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ANCHOR = 3'd1;
  localparam logic [KIND_W-1:0] KIND_END    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_INTERP = 3'd3;
  localparam logic [KIND_W-1:0] KIND_STOP   = 3'd4;

  typedef struct packed {
    logic capture;
    logic setup;
    logic grid;
    logic mul;
    logic div_step;
    logic fix;
    logic emit;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              grid_done;
    logic              div_done;
    logic              out_free;
  } stat_t;

endpackage

[rtl/sur_ctrl.sv]
// ----------------------------------------------------------------------------
// sur_ctrl
// Sequencer for the resampler: takes one breakpoint, walks the grid points
// it settles, steps the divider for interpolated points and hands each value
// to the output register.
// ----------------------------------------------------------------------------
module sur_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  sur_pkg::stat_t stat,
  output sur_pkg::cmd_t  cmd
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SETUP  = 4'd1;
  localparam logic [3:0] ST_GRID   = 4'd2;
  localparam logic [3:0] ST_EVAL   = 4'd3;
  localparam logic [3:0] ST_MUL    = 4'd4;
  localparam logic [3:0] ST_DIV    = 4'd5;
  localparam logic [3:0] ST_FIX    = 4'd6;
  localparam logic [3:0] ST_EMIT   = 4'd7;
  localparam logic [3:0] ST_FINISH = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_GRID;
      end
      ST_GRID: begin
        if (stat.grid_done) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.grid  = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (stat.kind == sur_pkg::KIND_STOP) begin
          state_nxt = ST_FINISH;
        end else if (stat.kind == sur_pkg::KIND_INTERP) begin
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (stat.div_done) begin
          state_nxt = ST_FIX;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_GRID;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_capture_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == ST_SETUP))
    else $error("capture did not lead to setup");

  a_div_then_fix: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && stat.div_done) |=> cmd.fix)
    else $error("divider finish not followed by fix");

  a_emit_after_emit_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (state_r == ST_GRID))
    else $error("emit did not return to grid walk");

endmodule

[rtl/sur_dp.sv]
// ----------------------------------------------------------------------------
// sur_dp
// Datapath of the resampler: configuration and spectrum state, grid
// wavelength, point classification, magnitude multiply, restoring divider
// and the output register.
// ----------------------------------------------------------------------------
module sur_dp #(
  parameter int GRID_POINTS = sur_pkg::GRID_POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sur_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sur_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic [sur_pkg::WAVE_W-1:0]          in_wavelength,
  input  logic signed [sur_pkg::VAL_W-1:0]    in_intensity,
  input  logic                                in_last_point,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [sur_pkg::INDEX_W-1:0]         out_grid_index,
  output logic signed [sur_pkg::VAL_W-1:0]    out_grid_value,
  output logic                                out_final_value,
  input  sur_pkg::cmd_t                       cmd,
  output sur_pkg::stat_t                      stat
);

  localparam int IDX_W = $clog2(GRID_POINTS + 1);
  localparam int SP_W  = sur_pkg::WAVE_W + IDX_W;
  localparam int G_W   = sur_pkg::WAVE_W + IDX_W + 1;
  localparam int MAG_W = 48;

  logic [sur_pkg::CFG_W-1:0]  start_r;
  logic [sur_pkg::CFG_W-1:0]  step_r;

  logic [sur_pkg::WAVE_W-1:0] w_r;
  logic [sur_pkg::VAL_W-1:0]  p_r;
  logic                       last_r;

  logic [sur_pkg::WAVE_W-1:0] prior_w_r;
  logic [sur_pkg::VAL_W-1:0]  prior_i_r;
  logic [sur_pkg::VAL_W-1:0]  anchor_r;
  logic [IDX_W-1:0]           idx_r;
  logic                       seen_first_r;
  logic                       spanned_r;
  logic                       widened_r;

  logic [31:0]                dp_mag_r;
  logic                       dp_neg_r;

  logic [G_W-1:0]             g_r;
  logic [sur_pkg::WAVE_W-1:0] den_r;
  logic [15:0]                rem_r;
  logic [sur_pkg::DIV_STEPS-1:0] sh_r;
  logic [sur_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [sur_pkg::VAL_W-1:0]  q_r;

  logic                       out_valid_r;
  logic [sur_pkg::INDEX_W-1:0] out_index_r;
  logic [sur_pkg::VAL_W-1:0]  out_value_r;
  logic                       out_final_r;

  // setup path
  logic [sur_pkg::WAVE_W-1:0] pw_eff;
  logic [sur_pkg::VAL_W-1:0]  pi_eff;
  logic [sur_pkg::WAVE_W-1:0] w_clamp;
  logic [32:0]                dp_up;
  logic [32:0]                dp_dn;

  // grid and classification
  logic [sur_pkg::WAVE_W+IDX_W-1:0] step_prod;
  logic [G_W-1:0]             g_nxt;
  logic [G_W-1:0]             pw_g;
  logic [G_W-1:0]             w_g;
  logic [sur_pkg::KIND_W-1:0] kind;
  logic [sur_pkg::WAVE_W-1:0] num;
  logic [MAG_W-1:0]           mag_nxt;

  // divider and output
  logic [16:0]                div_t;
  logic                       div_ge;
  logic [16:0]                div_sub;
  logic [sur_pkg::VAL_W-1:0]  end_val;
  logic [sur_pkg::VAL_W-1:0]  emit_val;

  assign pw_eff  = seen_first_r ? prior_w_r : w_r;
  assign pi_eff  = seen_first_r ? prior_i_r : p_r;
  assign w_clamp = (w_r < pw_eff) ? pw_eff : w_r;
  assign dp_up   = {p_r[31], p_r} - {pi_eff[31], pi_eff};
  assign dp_dn   = {pi_eff[31], pi_eff} - {p_r[31], p_r};

  assign step_prod = SP_W'(step_r) * SP_W'(idx_r);
  assign g_nxt     = G_W'(start_r) + G_W'(step_prod);
  assign pw_g      = G_W'(prior_w_r);
  assign w_g       = G_W'(w_r);

  always_comb begin
    priority if (g_r < pw_g) begin
      kind = sur_pkg::KIND_ZERO;
    end else if (g_r == pw_g) begin
      priority if (widened_r) begin
        kind = sur_pkg::KIND_ANCHOR;
      end else if (last_r) begin
        kind = sur_pkg::KIND_END;
      end else begin
        kind = sur_pkg::KIND_STOP;
      end
    end else if (g_r < w_g) begin
      kind = sur_pkg::KIND_INTERP;
    end else if (g_r == w_g) begin
      kind = last_r ? sur_pkg::KIND_END : sur_pkg::KIND_STOP;
    end else begin
      kind = last_r ? sur_pkg::KIND_ZERO : sur_pkg::KIND_STOP;
    end
  end

  assign num     = g_r[sur_pkg::WAVE_W-1:0] - prior_w_r;
  assign mag_nxt = MAG_W'(dp_mag_r) * MAG_W'(num);

  assign div_t   = {rem_r, sh_r[sur_pkg::DIV_STEPS-1]};
  assign div_ge  = (div_t >= {1'b0, den_r});
  assign div_sub = div_t - {1'b0, den_r};

  assign end_val = spanned_r ? p_r : anchor_r;

  always_comb begin
    unique case (kind)
      sur_pkg::KIND_ZERO:   emit_val = '0;
      sur_pkg::KIND_ANCHOR: emit_val = anchor_r;
      sur_pkg::KIND_END:    emit_val = end_val;
      sur_pkg::KIND_INTERP: emit_val = prior_i_r + q_r;
      default:              emit_val = '0;
    endcase
  end

  assign stat.kind      = kind;
  assign stat.grid_done = (idx_r == IDX_W'(GRID_POINTS));
  assign stat.div_done  = (cnt_r == '0);
  assign stat.out_free  = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_grid_index  = out_index_r;
  assign out_grid_value  = out_value_r;
  assign out_final_value = out_final_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r      <= sur_pkg::GRID_START_RST;
      step_r       <= sur_pkg::GRID_STEP_RST;
      prior_w_r    <= '0;
      prior_i_r    <= '0;
      anchor_r     <= '0;
      idx_r        <= '0;
      seen_first_r <= 1'b0;
      spanned_r    <= 1'b0;
      widened_r    <= 1'b0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == sur_pkg::REG_GRID_START) begin
          start_r <= cfg_wdata;
        end
        if (cfg_index == sur_pkg::REG_GRID_STEP) begin
          step_r <= cfg_wdata;
        end
      end
      if (cmd.setup) begin
        if (!seen_first_r) begin
          prior_w_r <= w_r;
          prior_i_r <= p_r;
          anchor_r  <= p_r;
        end
        seen_first_r <= 1'b1;
        widened_r    <= (w_clamp > pw_eff);
        spanned_r    <= (seen_first_r && spanned_r) || (w_clamp > pw_eff);
      end
      if (cmd.mul) begin
        cnt_r <= sur_pkg::DIV_CNT_W'(sur_pkg::DIV_STEPS);
      end else if (cmd.div_step) begin
        cnt_r <= cnt_r - sur_pkg::DIV_CNT_W'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        idx_r       <= idx_r + IDX_W'(1);
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.finish) begin
        if (widened_r) begin
          anchor_r <= p_r;
        end
        prior_w_r <= w_r;
        prior_i_r <= p_r;
        if (last_r) begin
          idx_r        <= '0;
          seen_first_r <= 1'b0;
          spanned_r    <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      w_r    <= in_wavelength;
      p_r    <= in_intensity;
      last_r <= in_last_point;
    end
    if (cmd.setup) begin
      w_r      <= w_clamp;
      dp_neg_r <= dp_up[32];
      dp_mag_r <= dp_up[32] ? dp_dn[31:0] : dp_up[31:0];
    end
    if (cmd.grid) begin
      g_r <= g_nxt;
    end
    if (cmd.mul) begin
      den_r <= w_r - prior_w_r;
      rem_r <= 16'(mag_nxt[MAG_W-1:sur_pkg::DIV_STEPS]);
      sh_r  <= mag_nxt[sur_pkg::DIV_STEPS-1:0];
    end else if (cmd.div_step) begin
      rem_r <= div_ge ? div_sub[15:0] : div_t[15:0];
      sh_r  <= {sh_r[sur_pkg::DIV_STEPS-2:0], div_ge};
    end
    if (cmd.fix) begin
      q_r <= dp_neg_r ? (~sh_r[31:0] + {31'd0, (rem_r == '0)}) : sh_r[31:0];
    end
    if (cmd.emit) begin
      out_index_r <= sur_pkg::INDEX_W'(idx_r);
      out_value_r <= emit_val;
      out_final_r <= (idx_r == IDX_W'(GRID_POINTS - 1));
    end
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IDX_W'(GRID_POINTS))
    else $error("grid index ran past the grid");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || !out_stall))
    else $error("result overwritten while held");

  a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (cnt_r != '0))
    else $error("divider stepped past its count");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && last_r) |=> (idx_r == '0 && !seen_first_r && !spanned_r))
    else $error("spectrum end did not clear state");

endmodule

[rtl/spectrum_uniform_resampler_core.sv]
// ----------------------------------------------------------------------------
// spectrum_uniform_resampler_core
// Resamples a breakpoint spectrum onto a uniform wavelength grid with
// floored linear interpolation.
//
//   channel | ports                               | direction
//   in      | in_valid/in_stall, breakpoint       | consumed
//   out     | out_valid/out_stall, grid value     | produced
//   cfg     | cfg_we, cfg_index, cfg_wdata        | consumed, write only
//
// Each breakpoint is captured and set up, then the grid walk emits each grid
// point it settles as zero, an anchor or an end value, or interpolates it
// through the 33-step restoring divider, until a stop point or grid end.
// Reset is synchronous on rst_n and restores the grid registers.
// A held result stalls the walk only when the next one is ready.
// ----------------------------------------------------------------------------
module spectrum_uniform_resampler_core #(
  parameter int GRID_POINTS = sur_pkg::GRID_POINTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sur_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sur_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [sur_pkg::WAVE_W-1:0]       in_wavelength,
  input  logic signed [sur_pkg::VAL_W-1:0] in_intensity,
  input  logic                             in_last_point,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [sur_pkg::INDEX_W-1:0]      out_grid_index,
  output logic signed [sur_pkg::VAL_W-1:0] out_grid_value,
  output logic                             out_final_value
);

  sur_pkg::cmd_t  cmd;
  sur_pkg::stat_t stat;

  sur_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  sur_dp #(
    .GRID_POINTS (GRID_POINTS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_wavelength   (in_wavelength),
    .in_intensity    (in_intensity),
    .in_last_point   (in_last_point),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_grid_index  (out_grid_index),
    .out_grid_value  (out_grid_value),
    .out_final_value (out_final_value),
    .cmd             (cmd),
    .stat            (stat)
  );

endmodule
